### src/audio_level_bar_column_renderer_defines.svh
// assertion macros for the bar column renderer
`ifndef AUDIO_LEVEL_BAR_COLUMN_RENDERER_DEFINES_SVH
`define AUDIO_LEVEL_BAR_COLUMN_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define ALB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, clocked on clk, off during reset
`define ALB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALB_ASSERT_IMP(lbl, ante, cons, msg)
`define ALB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/alb_pkg.sv
// shared constants and controller/datapath interface types
package alb_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 20;
    localparam int CNT_W     = 9;
    localparam int COLUMNS   = 128;
    localparam int HEIGHT_PX = 64;
    localparam int PAGE_ROWS = 8;
    localparam int MAX_PAGES = 8;
    localparam int PAGES     = (HEIGHT_PX / PAGE_ROWS > MAX_PAGES) ? MAX_PAGES
                                                                   : HEIGHT_PX / PAGE_ROWS;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int THR_W     = $clog2(HEIGHT_PX + 1);
    localparam int PROD_W    = SUM_W + THR_W;
    localparam int AVG_SHIFT = 11;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MAX_COUNT = 256;

    localparam logic [SAMPLE_W-1:0] MID_SCALE = SAMPLE_W'(2048);

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic calc;
        logic emit_next;
    } alb_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic close;
        logic div_done;
        logic last_page;
    } alb_status_t;

endpackage

### src/audio_level_bar_column_renderer.sv
// top level of the audio level bar column renderer
//
// in channel: one beat per 12-bit sample (sample, block_end) on in_valid/in_ready
// out channel: one beat per page byte (page_byte, page_index, column_index,
//   last_of_column) on out_valid/out_ready, top page first
// config: cfg_wr_en/cfg_wr_data load samples_per_column, write only while idle
// a beat that does not close a column is added to the sum and sample count
// a closing beat (count reached or block_end) starts a serial divide of the
//   magnitude sum by the configured count, a height step, then 8 page beats
// one column is worked on at a time: in_ready is low after the closing beat
//   until the last page beat is taken
// a stall on out_ready holds the current page beat and payload unchanged
// reset clears the sum, sample count and column counter, and sets the count to 1
module audio_level_bar_column_renderer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [alb_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [alb_pkg::SAMPLE_W-1:0] sample,
    input  logic                         block_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   page_byte,
    output logic [2:0]                   page_index,
    output logic [6:0]                   column_index,
    output logic                         last_of_column
);
    import alb_pkg::*;

    // controller to datapath commands and the status coming back
    alb_cmd_t    cmd;
    alb_status_t status;

    // sequencing: idle, divide, height, emit
    alb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // accumulate, divide, scale and render the column
    alb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .sample         (sample),
        .block_end      (block_end),
        .page_byte      (page_byte),
        .page_index     (page_index),
        .column_index   (column_index),
        .last_of_column (last_of_column)
    );

endmodule

### src/alb_ctrl.sv
// sequencing state machine for the bar column renderer
`include "audio_level_bar_column_renderer_defines.svh"
module alb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  alb_pkg::alb_status_t status,
    output alb_pkg::alb_cmd_t    cmd
);
    import alb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_CALC = 4'b0100,
        ST_EMIT = 4'b1000
    } alb_state_t;

    alb_state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        cmd.accept    = in_ready && in_valid;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.calc      = (state_reg == ST_CALC);
        cmd.emit_next = out_valid && out_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.close)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.emit_next && status.last_page)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ALB_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken while column is emitted")
    `ALB_ASSERT_NXT(a_close_divides, cmd.accept && status.close, state_reg == ST_DIV,
                    "closing beat did not start the divide")
    `ALB_ASSERT_NXT(a_div_to_calc, cmd.div_step && status.div_done, state_reg == ST_CALC,
                    "divide end did not reach the height step")
    `ALB_ASSERT_NXT(a_last_to_idle, cmd.emit_next && status.last_page, in_ready,
                    "last page beat did not return to idle")

endmodule

### src/alb_dp.sv
// accumulator, serial divider, height scaling and page byte datapath
module alb_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  alb_pkg::alb_cmd_t            cmd,
    output alb_pkg::alb_status_t         status,
    input  logic                         cfg_wr_en,
    input  logic [alb_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic [alb_pkg::SAMPLE_W-1:0] sample,
    input  logic                         block_end,
    output logic [7:0]                   page_byte,
    output logic [2:0]                   page_index,
    output logic [6:0]                   column_index,
    output logic                         last_of_column
);
    import alb_pkg::*;

    logic [CNT_W-1:0]    spc_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [COL_W-1:0]    col_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [2:0]          page_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [SAMPLE_W-1:0] mag;
    logic [CNT_W:0]      trial;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   height;
    logic [THR_W-1:0]    height_clamped;

    // zero acts as one, above range saturates
    always_comb
    begin
        priority if (spc_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (spc_reg > CNT_W'(MAX_COUNT))
        begin
            n_eff = CNT_W'(MAX_COUNT);
        end
        else
        begin
            n_eff = spc_reg;
        end
    end

    assign mag      = (sample >= MID_SCALE) ? (sample - MID_SCALE) : (MID_SCALE - sample);
    assign sum_next = sum_reg + SUM_W'(mag);

    assign status.close     = ((CNT_W + 1)'(cnt_reg) + 1'b1 >= (CNT_W + 1)'(n_eff)) || block_end;
    assign status.div_done  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.last_page = (page_reg == 3'(PAGES - 1));

    // restoring divide, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[SUM_W-1]} - (CNT_W + 1)'(n_eff);

    assign prod   = PROD_W'(quo_reg) * PROD_W'(HEIGHT_PX);
    assign height = prod >> AVG_SHIFT;
    assign height_clamped = (height > PROD_W'(HEIGHT_PX)) ? THR_W'(HEIGHT_PX)
                                                          : THR_W'(height);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg  <= CNT_W'(1);
            sum_reg  <= '0;
            cnt_reg  <= '0;
            col_reg  <= '0;
            step_reg <= '0;
            page_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spc_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                if (status.close)
                begin
                    sum_reg  <= '0;
                    cnt_reg  <= '0;
                    step_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.calc)
            begin
                page_reg <= '0;
            end
            if (cmd.emit_next)
            begin
                page_reg <= page_reg + 1'b1;
                if (status.last_page)
                begin
                    col_reg <= (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.close)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[CNT_W])
            begin
                rem_reg <= trial[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[CNT_W-2:0], quo_reg[SUM_W-1]};
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.calc)
        begin
            thr_reg <= THR_W'(HEIGHT_PX) - height_clamped;
        end
    end

    // a pixel is lit when its row is at or below the threshold row
    always_comb
    begin
        for (int b = 0; b < PAGE_ROWS; b++)
        begin
            page_byte[b] = ((THR_W + 3)'({page_reg, 3'(b)}) >= (THR_W + 3)'(thr_reg));
        end
    end

    assign page_index     = page_reg;
    assign column_index   = 7'(col_reg);
    assign last_of_column = status.last_page;

endmodule
